[sv/sld_pkg.sv]
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types and constants for the sync/length packet deframer.
// ----------------------------------------------------------------------------
package sld_pkg;

	// default framing geometry, in bytes from the first sync byte
	localparam int HEADER_LEN_DEF    = 67;
	localparam int LENGTH_OFFSET_DEF = 63;

	// header position counter width (fixed by the header format)
	localparam int POS_W = 8;

	// length field and payload counter
	localparam int LEN_W  = 32;
	localparam int LEFT_W = 31;

	localparam int QUEUE_DEPTH = 4;

	// one queue entry: a single byte, or a sync pair (byte0 then byte1)
	typedef struct packed {
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       pair;
		logic       last;
		logic       err;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t entry;
	} push_t;

	typedef struct packed {
		logic   nempty;
		entry_t entry;
	} head_t;

endpackage

[sv/sld_front.sv]
// ----------------------------------------------------------------------------
// sld_front
// Framing state machine: hunts for the sync word, walks the header, captures
// the length and counts the payload. Pushes result entries to the queue.
// ----------------------------------------------------------------------------
module sld_front #(
	parameter int HEADER_LEN    = sld_pkg::HEADER_LEN_DEF,
	parameter int LENGTH_OFFSET = sld_pkg::LENGTH_OFFSET_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           accept,
	input  logic [7:0]     data_byte,
	input  logic [15:0]    sync_word,
	output sld_pkg::push_t push
);

	localparam logic [1:0] MODE_HUNT    = 2'd0;
	localparam logic [1:0] MODE_HEADER  = 2'd1;
	localparam logic [1:0] MODE_PAYLOAD = 2'd2;

	localparam int PW = sld_pkg::POS_W;

	logic [1:0]                 mode_q;
	logic [7:0]                 prev_q;
	logic                       held_q;
	logic [PW-1:0]              pos_q;
	logic [sld_pkg::LEN_W-1:0]  len_q;
	logic [sld_pkg::LEFT_W-1:0] left_q;

	logic [PW-1:0]              pos_next;
	logic                       in_field;
	logic [sld_pkg::LEN_W-1:0]  len_next;
	logic                       hdr_end;
	logic                       match;
	logic                       pay_end;

	assign pos_next = pos_q + 1'b1;
	assign in_field = ({1'b0, pos_q} >= (PW+1)'(LENGTH_OFFSET)) &&
		({1'b0, pos_q} < (PW+1)'(LENGTH_OFFSET + 4));
	assign len_next = in_field ? {len_q[sld_pkg::LEN_W-9:0], data_byte} : len_q;
	assign hdr_end  = pos_next >= PW'(HEADER_LEN);
	assign match    = held_q && ({prev_q, data_byte} == sync_word);
	// a zero count can only be seen if the mode was never set up; treat as end
	assign pay_end  = (left_q == sld_pkg::LEFT_W'(1)) || (left_q == '0);

	always_comb begin
		push = '0;
		push.entry.byte1 = data_byte;
		push.entry.byte0 = prev_q;
		unique case (mode_q)
			MODE_HEADER: begin
				push.valid = accept;
				if (hdr_end) begin
					push.entry.last = len_next[sld_pkg::LEN_W-1] || (len_next == '0);
					push.entry.err  = len_next[sld_pkg::LEN_W-1];
				end
			end
			MODE_PAYLOAD: begin
				push.valid      = accept;
				push.entry.last = pay_end;
			end
			default: begin
				push.valid      = accept && match;
				push.entry.pair = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_HUNT;
			prev_q <= '0;
			held_q <= 1'b0;
			pos_q  <= '0;
			len_q  <= '0;
			left_q <= '0;
		end else if (accept) begin
			unique case (mode_q)
				MODE_HEADER: begin
					pos_q <= pos_next;
					len_q <= len_next;
					if (hdr_end) begin
						if (len_next[sld_pkg::LEN_W-1] || (len_next == '0)) begin
							mode_q <= MODE_HUNT;
							prev_q <= '0;
							held_q <= 1'b0;
						end else begin
							left_q <= len_next[sld_pkg::LEFT_W-1:0];
							mode_q <= MODE_PAYLOAD;
						end
					end
				end
				MODE_PAYLOAD: begin
					if (left_q != '0) begin
						left_q <= left_q - 1'b1;
					end
					if (pay_end) begin
						mode_q <= MODE_HUNT;
						prev_q <= '0;
						held_q <= 1'b0;
					end
				end
				default: begin
					if (match) begin
						mode_q <= MODE_HEADER;
						pos_q  <= PW'(2);
						len_q  <= '0;
						left_q <= '0;
						prev_q <= '0;
						held_q <= 1'b0;
					end else begin
						mode_q <= MODE_HUNT;
						prev_q <= data_byte;
						held_q <= 1'b1;
					end
				end
			endcase
		end
	end

endmodule

[sv/sld_queue.sv]
// ----------------------------------------------------------------------------
// sld_queue
// Small FIFO of result entries between the framer and the output stage.
// ----------------------------------------------------------------------------
module sld_queue #(
	parameter int DEPTH = sld_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sld_pkg::push_t push,
	input  logic           pop,
	output sld_pkg::head_t head,
	output logic           full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	sld_pkg::entry_t mem_q [DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   count_q;

	logic do_push;
	logic do_pop;

	assign full        = count_q == CW'(DEPTH);
	assign head.nempty = count_q != '0;
	assign head.entry  = mem_q[rd_q];
	assign do_push     = push.valid && !full;
	assign do_pop      = pop && head.nempty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[sv/sld_back.sv]
// ----------------------------------------------------------------------------
// sld_back
// Output stage: splits sync pairs into two beats and holds the result
// register under stall.
// ----------------------------------------------------------------------------
module sld_back (
	input  logic           clk,
	input  logic           arst_n,
	input  sld_pkg::head_t head,
	output logic           pop,
	input  logic           result_stall,
	output logic           result_valid,
	output logic [7:0]     out_byte,
	output logic           first,
	output logic           last,
	output logic           length_error
);

	logic       valid_q;
	logic       phase_q;
	logic [7:0] byte_q;
	logic       first_q;
	logic       last_q;
	logic       err_q;
	logic       load;
	logic       lead;

	assign load = head.nempty && (!valid_q || !result_stall);
	// leading sync byte of a pair goes out first, entry stays at the head
	assign lead = head.entry.pair && !phase_q;
	assign pop  = load && !lead;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			phase_q <= lead;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q  <= lead ? head.entry.byte0 : head.entry.byte1;
			first_q <= lead;
			last_q  <= !lead && head.entry.last;
			err_q   <= !lead && head.entry.err;
		end
	end

	assign result_valid = valid_q;
	assign out_byte     = byte_q;
	assign first        = first_q;
	assign last         = last_q;
	assign length_error = err_q;

endmodule

[sv/sync_length_packet_deframer.sv]
// ----------------------------------------------------------------------------
// sync_length_packet_deframer
// Byte-stream packet deframer. While hunting it looks at each pair of
// consecutive bytes for the 16-bit big-endian sync word; on a match both
// sync bytes leave as the packet start (first on the leading one) and the
// rest of the HEADER_LEN-byte header follows. The four bytes at
// LENGTH_OFFSET give a big-endian payload length; that many payload bytes are
// passed and the final one carries last. A zero length ends the packet on
// the final header byte; a length with bit 31 set does the same and also
// raises length_error. After any packet end two fresh bytes are needed for
// the next sync. One input byte is taken every clock cycle while the queue
// has room (data_stall low); the output gives one beat per cycle while
// result_stall is low, and the extra beat of a sync match (two beats from
// one byte) is absorbed by the four-entry queue between the framing state
// machine and the output register, which each byte passes in turn. Write
// sync_word only while the block is idle; the write port is always ready.
// ----------------------------------------------------------------------------
module sync_length_packet_deframer #(
	parameter int HEADER_LEN    = sld_pkg::HEADER_LEN_DEF,
	parameter int LENGTH_OFFSET = sld_pkg::LENGTH_OFFSET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	// sync word register write
	input  logic        sync_word_valid,
	output logic        sync_word_ready,
	input  logic [15:0] sync_word,

	// input byte stream
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,

	// framed output stream
	output logic        result_valid,
	input  logic        result_stall,
	output logic [7:0]  out_byte,
	output logic        first,
	output logic        last,
	output logic        length_error
);

	logic [15:0]    sync_word_q;
	logic           accept;
	logic           full;
	logic           pop;
	sld_pkg::push_t push;
	sld_pkg::head_t head;

	// config register: always writable
	assign sync_word_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_word_q <= '0;
		end else if (sync_word_valid) begin
			sync_word_q <= sync_word;
		end
	end

	// hold off the source only when the queue has no room
	assign data_stall = full;
	assign accept     = data_valid && !data_stall;

	sld_front #(
		.HEADER_LEN   (HEADER_LEN),
		.LENGTH_OFFSET(LENGTH_OFFSET)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.data_byte(data_byte),
		.sync_word(sync_word_q),
		.push     (push)
	);

	sld_queue #(
		.DEPTH(sld_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.full  (full)
	);

	sld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.pop         (pop),
		.result_stall(result_stall),
		.result_valid(result_valid),
		.out_byte    (out_byte),
		.first       (first),
		.last        (last),
		.length_error(length_error)
	);

endmodule

[sv/sld_checker.sv]
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks on the deframer output stream.
// ----------------------------------------------------------------------------
module sld_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        result_valid,
	input logic        result_stall,
	input logic [7:0]  out_byte,
	input logic        first,
	input logic        last,
	input logic        length_error
);

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(out_byte) &&
		$stable(first) && $stable(last) && $stable(length_error))
		else $error("stalled output beat changed");

	// the leading sync byte never ends a packet
	a_first: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && first |-> !last && !length_error)
		else $error("first beat flagged as packet end");

	// an aborted packet always ends there
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && length_error |-> last)
		else $error("length error without last");

	// second sync byte follows straight after the first is taken
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && first && !result_stall |=> result_valid && !first)
		else $error("sync pair split");

endmodule

bind sync_length_packet_deframer sld_checker u_sld_checker (.*);
